@@ design/pncid_pkg.sv @@
// Package for the padded name CRC-32 identifier.
// Holds the shared types, constants and the byte-wise CRC-32 and case-folding functions.
// No dependencies.
package pncid_pkg;

   localparam logic [7:0]  MAX_NAME_LEN = 8'd255;
   localparam logic [31:0] CRC_POLY     = 32'hEDB88320;
   localparam logic [31:0] CRC_INIT     = 32'hFFFFFFFF;

   typedef struct packed {
      logic [31:0] crc;
      logic [7:0]  count;
      logic [7:0]  first_char;
      logic        overflow;
   } name_state_type;

   function automatic logic [31:0] crc_feed(input logic [31:0] crc, input logic [7:0] data);
      logic [31:0] c;
      c = crc ^ {24'd0, data};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

   function automatic logic [7:0] to_upper(input logic [7:0] ch);
      logic [7:0] u;
      u = ch;
      if (ch >= 8'h61 && ch <= 8'h7A) begin
         u = ch - 8'h20;
      end
      return u;
   endfunction

endpackage

@@ design/pncid_accum.sv @@
// Input register and running name state for the padded name CRC-32 identifier.
// Folds one character per item into the CRC and hands the closed name state downstream.
// Depends on pncid_pkg.
module pncid_accum (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [7:0]               req_tdata,   // name_byte
   input  logic                     req_tuser,   // byte_present
   input  logic                     req_tlast,   // last
   output logic                     close_valid,
   input  logic                     close_ready,
   output pncid_pkg::name_state_type close_state
);
   import pncid_pkg::*;

   logic           in_valid_ff, in_valid_in;
   logic [7:0]     in_byte_ff;
   logic           in_present_ff;
   logic           in_last_ff;
   name_state_type state_ff, state_in;
   name_state_type updated;
   logic           advance;
   logic [7:0]     upper;

   assign advance    = in_valid_ff && (!in_last_ff || close_ready);
   assign req_tready = !in_valid_ff || advance;
   assign upper      = to_upper(in_byte_ff);

   always_comb begin
      updated = state_ff;
      if (in_present_ff) begin
         if (state_ff.count < MAX_NAME_LEN) begin
            if (state_ff.count[1:0] == 2'd0) begin
               updated.first_char = upper;
            end
            updated.crc   = crc_feed(state_ff.crc, upper);
            updated.count = state_ff.count + 8'd1;
         end else begin
            updated.overflow = 1'b1;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      if (advance) begin
         if (in_last_ff) begin
            state_in = '{crc: CRC_INIT, count: 8'd0, first_char: 8'd0, overflow: 1'b0};
         end else begin
            state_in = updated;
         end
      end
   end

   assign in_valid_in = req_tready ? req_tvalid : in_valid_ff;
   assign close_valid = in_valid_ff && in_last_ff;
   assign close_state = updated;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         state_ff    <= '{crc: CRC_INIT, count: 8'd0, first_char: 8'd0, overflow: 1'b0};
      end else begin
         in_valid_ff <= in_valid_in;
         state_ff    <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready) begin
         in_byte_ff    <= req_tdata;
         in_present_ff <= req_tuser;
         in_last_ff    <= req_tlast;
      end
   end

endmodule

@@ design/pncid_pad.sv @@
// Padding and result stages for the padded name CRC-32 identifier.
// For a length not a multiple of four, feeds the length modulo four as a byte, then the
// repeated group character; inverts and holds the result. Depends on pncid_pkg.
module pncid_pad (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     close_valid,
   output logic                     close_ready,
   input  pncid_pkg::name_state_type close_state,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [39:0]              rsp_tdata,   // name_id, name_length
   output logic                     rsp_tuser    // was_truncated
);
   import pncid_pkg::*;

   logic           a_valid_ff, a_valid_in;
   logic           b_valid_ff, b_valid_in;
   logic           out_valid_ff, out_valid_in;
   name_state_type a_ff, b_ff, b_in;
   logic [39:0]    out_data_ff, out_data_in;
   logic           out_flag_ff;
   logic           a_ready, b_ready, out_ready;
   logic [31:0]    crc_one, crc_two, crc_final;

   assign out_ready   = !out_valid_ff || rsp_tready;
   assign b_ready     = !b_valid_ff || out_ready;
   assign a_ready     = !a_valid_ff || b_ready;
   assign close_ready = a_ready;

   assign a_valid_in   = a_ready ? close_valid : a_valid_ff;
   assign b_valid_in   = b_ready ? a_valid_ff : b_valid_ff;
   assign out_valid_in = out_ready ? b_valid_ff : out_valid_ff;

   always_comb begin
      b_in = a_ff;
      if (a_ff.count[1:0] != 2'd0) begin
         b_in.crc = crc_feed(a_ff.crc, {6'd0, a_ff.count[1:0]});
      end
   end

   assign crc_one = crc_feed(b_ff.crc, b_ff.first_char);
   assign crc_two = crc_feed(crc_one, b_ff.first_char);

   always_comb begin
      case (b_ff.count[1:0])
         2'd1:    crc_final = crc_two;
         2'd2:    crc_final = crc_one;
         default: crc_final = b_ff.crc;
      endcase
   end

   assign out_data_in = {b_ff.count, ~crc_final};

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         a_valid_ff   <= a_valid_in;
         b_valid_ff   <= b_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready) begin
         a_ff <= close_state;
      end
      if (b_ready) begin
         b_ff <= b_in;
      end
      if (out_ready) begin
         out_data_ff <= out_data_in;
         out_flag_ff <= b_ff.overflow;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_flag_ff;

endmodule

@@ design/padded_name_crc32_id_top.sv @@
// Top level of the padded name CRC-32 identifier.
// Instantiates pncid_accum and pncid_pad; depends on pncid_pkg.
//
// Takes one name character per cycle while not stalled (req_tuser = character present,
// req_tlast = end of name) and returns, for each end of name, the inverted reflected CRC-32
// of the upper-cased name padded to a multiple of four, the kept length and a truncation
// flag. Characters past 255 are dropped. An item is accepted every cycle unless rsp_tready
// back-pressure stalls the pipeline; the result of a name passes through the input
// register, two padding stages and the result register. An idle item (no character, no
// end) is accepted and produces nothing.
module padded_name_crc32_id_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // name_byte
   input  logic        req_tuser,   // byte_present
   input  logic        req_tlast,   // last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // name_id [31:0], name_length [39:32]
   output logic        rsp_tuser    // was_truncated
);
   import pncid_pkg::*;

   logic           close_valid;
   logic           close_ready;
   name_state_type close_state;

   pncid_accum u_accum (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .close_valid (close_valid),
      .close_ready (close_ready),
      .close_state (close_state)
   );

   pncid_pad u_pad (
      .clock       (clock),
      .reset       (reset),
      .close_valid (close_valid),
      .close_ready (close_ready),
      .close_state (close_state),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

endmodule
